@@ hdl/button_click_classifier_assert.svh @@
// ----------------------------------------------------------------------------
// Button click classifier assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bcc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the button click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

	localparam int unsigned MS_W   = 16;
	localparam int unsigned CFG_IW = 2;

	localparam logic [MS_W-1:0] MS_CAP = {MS_W{1'b1}};

	localparam logic [MS_W-1:0] DEBOUNCE_RST     = 16'd20;
	localparam logic [MS_W-1:0] LONG_PRESS_RST   = 16'd1000;
	localparam logic [MS_W-1:0] SINGLE_WINDOW_RST = 16'd300;

	localparam logic [CFG_IW-1:0] CFG_DEBOUNCE      = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_LONG_PRESS    = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_SINGLE_WINDOW = 2'd2;

	typedef enum logic [2:0] {
		ST_RELEASED = 3'd0,
		ST_PUSHED   = 3'd1,
		ST_LONG     = 3'd2,
		ST_DOUBLE   = 3'd3,
		ST_INTER    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_SINGLE = 2'd1,
		ACT_DOUBLE = 2'd2,
		ACT_LONG   = 2'd3
	} action_t;

endpackage

`default_nettype wire

@@ hdl/button_click_classifier.sv @@
// A transfer accepted into the input register moves on to the result register, which drives the outputs.
// Throughput: one tick item per clock unless out_stall holds a result; the input register and result register
// form a two-stage pipe, and the result register alone gates the flow.
// Reset: arst_n clears status to released, stable count and last pressed flag to zero,
// and loads the windows with 20, 1000 and 300 ms.
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounces a millisecond-sampled button pin and reports single click,
// double click and long press, one action code per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [bcc_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [bcc_pkg::MS_W-1:0]    cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        pin_level,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       action_code
);

	logic [bcc_pkg::MS_W-1:0] debounce_q;
	logic [bcc_pkg::MS_W-1:0] long_press_q;
	logic [bcc_pkg::MS_W-1:0] single_window_q;

	logic                     valid_s1;
	logic                     pin_s1;
	logic                     valid_s2;
	bcc_pkg::action_t         action_s2;

	bcc_pkg::status_t         status_q;
	bcc_pkg::status_t         status_nxt;
	logic [bcc_pkg::MS_W-1:0] stable_q;
	logic [bcc_pkg::MS_W-1:0] stable_nxt;
	logic                     last_pressed_q;
	logic                     pressed;
	bcc_pkg::action_t         action_nxt;

	logic                     load_s2;
	logic                     gt_debounce;
	logic                     gt_long;
	logic                     gt_single;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= bcc_pkg::DEBOUNCE_RST;
			long_press_q    <= bcc_pkg::LONG_PRESS_RST;
			single_window_q <= bcc_pkg::SINGLE_WINDOW_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bcc_pkg::CFG_DEBOUNCE:      debounce_q      <= cfg_data;
				bcc_pkg::CFG_LONG_PRESS:    long_press_q    <= cfg_data;
				bcc_pkg::CFG_SINGLE_WINDOW: single_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign load_s2   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !load_s2;

	// stage 1: hold the raw sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_s1 <= pin_level;
		end
	end

	assign pressed    = !pin_s1;
	assign stable_nxt = (pressed != last_pressed_q) ? '0 :
		(stable_q == bcc_pkg::MS_CAP) ? stable_q : stable_q + 1'b1;

	assign gt_debounce = stable_nxt > debounce_q;
	assign gt_long     = stable_nxt > long_press_q;
	assign gt_single   = stable_nxt > single_window_q;

	always_comb begin
		status_nxt = status_q;
		unique case (status_q)
			bcc_pkg::ST_RELEASED: begin
				if (pressed && gt_debounce) status_nxt = bcc_pkg::ST_PUSHED;
			end
			bcc_pkg::ST_PUSHED: begin
				if (!pressed)     status_nxt = bcc_pkg::ST_INTER;
				else if (gt_long) status_nxt = bcc_pkg::ST_LONG;
			end
			bcc_pkg::ST_LONG,
			bcc_pkg::ST_DOUBLE: begin
				if (!pressed) status_nxt = bcc_pkg::ST_RELEASED;
			end
			bcc_pkg::ST_INTER: begin
				if (!pressed && gt_single)       status_nxt = bcc_pkg::ST_RELEASED;
				else if (pressed && gt_debounce) status_nxt = bcc_pkg::ST_DOUBLE;
			end
			default: status_nxt = bcc_pkg::ST_RELEASED;
		endcase
	end

	always_comb begin
		action_nxt = bcc_pkg::ACT_NONE;
		unique case (status_q)
			bcc_pkg::ST_PUSHED: begin
				if (pressed && gt_long) action_nxt = bcc_pkg::ACT_LONG;
			end
			bcc_pkg::ST_INTER: begin
				if (!pressed && gt_single)       action_nxt = bcc_pkg::ACT_SINGLE;
				else if (pressed && gt_debounce) action_nxt = bcc_pkg::ACT_DOUBLE;
			end
			default: action_nxt = bcc_pkg::ACT_NONE;
		endcase
	end

	// advance state only when the stage-1 item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q       <= bcc_pkg::ST_RELEASED;
			stable_q       <= '0;
			last_pressed_q <= 1'b0;
		end else if (valid_s1 && load_s2) begin
			status_q       <= status_nxt;
			stable_q       <= stable_nxt;
			last_pressed_q <= pressed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && load_s2) begin
			action_s2 <= action_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign action_code = action_s2;

endmodule

`default_nettype wire

@@ hdl/bcc_checker.sv @@
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the button click classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_click_classifier_assert.svh"

module bcc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] action_code
);

	`BCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(action_code), "result changed while stalled")
	`BCC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled result")
	`BCC_ASSERT_NOW(a_result_origin, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without a prior transfer")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.action_code (action_code)
);

`default_nettype wire

@@ tb/button_click_classifier_tb.sv @@
// ----------------------------------------------------------------------------
// button_click_classifier_tb
// Drives millisecond pin samples into the click classifier under random
// sender gaps and receiver stalls. A built-in predictor tracks the debounce
// count and press status and gives the expected action code for every tick.
// Covers the reset windows, every click kind, windows at their maximum,
// and several random window settings.
// ----------------------------------------------------------------------------
module button_click_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [bcc_pkg::MS_W-1:0] ms_t;

	localparam logic [bcc_pkg::CFG_IW-1:0] CFG_SPARE = 2'd3;
	localparam int unsigned LATENCY_WAIT = 3;
	localparam int unsigned MAX_HOLD_TICKS = 40;
	localparam int unsigned RANDOM_TICKS = 460;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [bcc_pkg::CFG_IW-1:0] cfg_index;
	ms_t                        cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic                       pin_level;
	logic                       out_valid;
	logic                       out_stall;
	logic [1:0]                 action_code;

	// predictor state and window shadows
	bcc_pkg::status_t press_status;
	ms_t              stable_ms;
	logic             last_pressed;
	ms_t              debounce_ms;
	ms_t              long_press_ms;
	ms_t              single_window_ms;

	bcc_pkg::action_t expected_actions[$];
	int unsigned fail_count;
	int unsigned tick_count;
	int unsigned burst_left;
	bit          idle_on;

	int unsigned stall_mode;
	int unsigned mode_left;
	logic [2:0]  stall_phase;

	button_click_classifier DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pin_level  (pin_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action_code(action_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bcc_pkg::action_t classify_tick(input logic pin);
		logic             pressed;
		bcc_pkg::action_t act;
		pressed = ~pin;
		act = bcc_pkg::ACT_NONE;
		if (pressed == last_pressed) begin
			if (stable_ms != bcc_pkg::MS_CAP)
				stable_ms = stable_ms + 1'b1;
		end else begin
			stable_ms = '0;
		end
		last_pressed = pressed;
		case (press_status)
		bcc_pkg::ST_RELEASED: begin
			if (pressed && stable_ms > debounce_ms)
				press_status = bcc_pkg::ST_PUSHED;
		end
		bcc_pkg::ST_PUSHED: begin
			if (!pressed) begin
				press_status = bcc_pkg::ST_INTER;
			end else if (stable_ms > long_press_ms) begin
				press_status = bcc_pkg::ST_LONG;
				act = bcc_pkg::ACT_LONG;
			end
		end
		bcc_pkg::ST_LONG, bcc_pkg::ST_DOUBLE: begin
			if (!pressed)
				press_status = bcc_pkg::ST_RELEASED;
		end
		bcc_pkg::ST_INTER: begin
			if (!pressed && stable_ms > single_window_ms) begin
				press_status = bcc_pkg::ST_RELEASED;
				act = bcc_pkg::ACT_SINGLE;
			end else if (pressed && stable_ms > debounce_ms) begin
				press_status = bcc_pkg::ST_DOUBLE;
				act = bcc_pkg::ACT_DOUBLE;
			end
		end
		default: press_status = bcc_pkg::ST_RELEASED;
		endcase
		return act;
	endfunction

	task automatic log_mismatch(input string what, input int want, input int got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		bcc_pkg::action_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_actions.size() == 0) begin
					log_mismatch("unexpected action_code", -1, action_code);
				end else begin
					want = expected_actions.pop_front();
					if (action_code !== want)
						log_mismatch("action_code", want, action_code);
				end
			end
			if (in_valid && !in_stall)
				expected_actions.push_back(classify_tick(pin_level));
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			stall_phase <= '0;
		end else begin
			stall_phase <= stall_phase + 1'b1;
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= stall_phase[2];
			default: out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	task automatic send_tick(input logic pin);
		int unsigned gap;
		if (burst_left == 0) begin
			if (idle_on) begin
				gap = $urandom_range(0, 4);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		pin_level <= pin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tick_count++;
	endtask

	task automatic hold_pin(input logic pin, input int unsigned ticks);
		repeat (ticks) send_tick(pin);
	endtask

	task automatic wait_quiet();
		int unsigned guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_actions.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic set_windows(input ms_t debounce,
	                           input ms_t long_press,
	                           input ms_t single_window);
		logic [bcc_pkg::CFG_IW-1:0] reg_idx [4];
		ms_t                        reg_val [4];
		reg_idx[0] = bcc_pkg::CFG_DEBOUNCE;
		reg_idx[1] = bcc_pkg::CFG_LONG_PRESS;
		reg_idx[2] = bcc_pkg::CFG_SINGLE_WINDOW;
		reg_idx[3] = CFG_SPARE;
		reg_val[0] = debounce;
		reg_val[1] = long_press;
		reg_val[2] = single_window;
		reg_val[3] = ms_t'($urandom);
		wait_quiet();
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= reg_idx[i];
			cfg_data <= reg_val[i];
			case (reg_idx[i])
			bcc_pkg::CFG_DEBOUNCE:      debounce_ms = reg_val[i];
			bcc_pkg::CFG_LONG_PRESS:    long_press_ms = reg_val[i];
			bcc_pkg::CFG_SINGLE_WINDOW: single_window_ms = reg_val[i];
			default: ;
			endcase
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_reset_windows();
		hold_pin(1'b1, 3);
		hold_pin(1'b0, 23);
		hold_pin(1'b1, 303);
		hold_pin(1'b0, 3);
	endtask

	task automatic test_click_kinds();
		set_windows(16'd0, 16'd3, 16'd1);
		hold_pin(1'b0, 2);
		hold_pin(1'b1, 4);
		hold_pin(1'b0, 2);
		hold_pin(1'b1, 1);
		hold_pin(1'b0, 3);
		hold_pin(1'b1, 2);
		hold_pin(1'b0, 7);
		hold_pin(1'b1, 2);
	endtask

	task automatic test_max_windows();
		idle_on = 1'b0;
		set_windows(16'd0, bcc_pkg::MS_CAP, bcc_pkg::MS_CAP);
		hold_pin(1'b0, MAX_HOLD_TICKS);
		hold_pin(1'b1, MAX_HOLD_TICKS);
		hold_pin(1'b0, 3);
		hold_pin(1'b1, 2);
		set_windows(bcc_pkg::MS_CAP, 16'd5, 16'd5);
		hold_pin(1'b0, MAX_HOLD_TICKS);
		hold_pin(1'b1, 2);
		hold_pin(1'b0, 3);
		idle_on = 1'b1;
	endtask

	task automatic test_random_settings();
		int unsigned stop_at;
		int unsigned phase_end;
		int unsigned dbc;
		int unsigned lng;
		int unsigned sgl;
		int unsigned press_len;
		int unsigned release_len;
		stop_at = tick_count + RANDOM_TICKS;
		while (tick_count < stop_at) begin
			dbc = $urandom_range(0, 5);
			lng = $urandom_range(0, 16);
			sgl = $urandom_range(0, 10);
			set_windows(ms_t'(dbc), ms_t'(lng), ms_t'(sgl));
			phase_end = tick_count + $urandom_range(80, 200);
			while (tick_count < phase_end && tick_count < stop_at) begin
				if ($urandom_range(0, 6) == 0) begin
					repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
				end else begin
					case ($urandom_range(0, 3))
					0: press_len = $urandom_range(1, dbc + 2);
					3: press_len = lng + $urandom_range(1, 4);
					default: press_len = $urandom_range(dbc + 1, lng + 1) + 1;
					endcase
					case ($urandom_range(0, 2))
					0: release_len = $urandom_range(1, sgl + 1);
					1: release_len = sgl + $urandom_range(1, 3);
					default: release_len = $urandom_range(1, 3);
					endcase
					hold_pin(1'b0, press_len);
					hold_pin(1'b1, release_len);
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pin_level = 1'b1;
		press_status = bcc_pkg::ST_RELEASED;
		stable_ms = '0;
		last_pressed = 1'b0;
		debounce_ms = 16'd20;
		long_press_ms = 16'd1000;
		single_window_ms = 16'd300;
		fail_count = 0;
		tick_count = 0;
		burst_left = 0;
		idle_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_windows();
		test_click_kinds();
		test_max_windows();
		test_random_settings();

		wait_quiet();
		repeat (5) @(posedge clk);
		if (expected_actions.size() != 0)
			log_mismatch("results never delivered", 0, expected_actions.size());
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
